### hdl/fns_pkg.sv
// Shared types, widths and constants for the FM noise squelch.
// Holds the raised-cosine ramp tables, built at elaboration from a fixed-point cosine.
// No dependencies; every other file refers to this package by scoped names.
package fns_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned PW_W       = 32;
  localparam int unsigned MAG_W      = 25;
  localparam int unsigned RAD_W      = 2 * MAG_W;
  localparam int unsigned REM_W      = MAG_W + 2;
  localparam int unsigned ACC_W      = LEVEL_W + COEF_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MODE_W     = 3;

  localparam int unsigned RAMP_UP_LEN   = 64;
  localparam int unsigned RAMP_DOWN_LEN = 64;
  localparam int unsigned UP_IDX_W      = $clog2(RAMP_UP_LEN + 1);
  localparam int unsigned DN_IDX_W      = $clog2(RAMP_DOWN_LEN + 1);

  // one root bit per step, one coefficient bit per step (coefficient plus its complement bit)
  localparam int unsigned SQRT_STEPS = MAG_W;
  localparam int unsigned AVG_STEPS  = COEF_W + 1;
  localparam int unsigned SER_CNT_W  = $clog2(SQRT_STEPS);

  localparam logic [CNT_W-1:0]   CNT_MAX         = '1;
  localparam logic [LEVEL_W-1:0] Q24_ONE         = 32'h0100_0000;
  localparam logic [LEVEL_W-1:0] SHORT_AVG_RESET = 32'h6400_0000;  // 100.0 in Q8.24
  localparam logic [LEVEL_W-1:0] LONG_AVG_RESET  = 32'h0100_0000;  // 1.0 in Q8.24

  localparam logic [COEF_W-1:0]  SHORT_COEF_RESET = 16'd65000;
  localparam logic [COEF_W-1:0]  LONG_COEF_RESET  = 16'd65530;
  localparam logic [LEVEL_W-1:0] UNMUTE_RESET     = 32'd8388608;
  localparam logic [LEVEL_W-1:0] TAIL_LVL_RESET   = 32'd9320676;
  localparam logic [CNT_W-1:0]   STARTUP_RESET    = 20'd4800;
  localparam logic [CNT_W-1:0]   MIN_TAIL_RESET   = 20'd2400;
  localparam logic [CNT_W-1:0]   MAX_TAIL_RESET   = 20'd72000;

  typedef enum logic [MODE_W-1:0] {
    MODE_MUTED     = 3'd0,
    MODE_RAMP_UP   = 3'd1,
    MODE_OPEN      = 3'd2,
    MODE_TAIL      = 3'd3,
    MODE_RAMP_DOWN = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE = 3'd0,
    CFG_SHORT_COEF = 3'd1,
    CFG_LONG_COEF  = 3'd2,
    CFG_UNMUTE_LVL = 3'd3,
    CFG_TAIL_LVL   = 3'd4,
    CFG_STARTUP    = 3'd5,
    CFG_MIN_TAIL   = 3'd6,
    CFG_MAX_TAIL   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_I,
    S_SQ_Q,
    S_SQRT,
    S_AVG,
    S_UPD,
    S_MUL_T,
    S_GATE_I,
    S_GATE_Q,
    S_FINISH
  } fns_state_e;

  // sequencing for the bit-serial units: load operands, then advance one digit
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  // ---------------------------------------------------------------------------
  // Ramp tables, elaboration only
  // ---------------------------------------------------------------------------
  localparam logic [63:0] Q28_ONE   = 64'd268435456;
  localparam logic [63:0] PI_Q28    = 64'd843314857;
  localparam logic [63:0] COS_DENS [7] = '{64'd182, 64'd132, 64'd90, 64'd56,
                                           64'd30, 64'd12, 64'd2};

  // cosine over [0, pi/2], Q28 in and out, nested Taylor series to x^14
  function automatic logic [63:0] cos_q28(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] t;
    x2  = (x * x) >> 28;
    acc = Q28_ONE;
    for (int k = 0; k < 7; k++) begin
      t   = ((x2 * acc) >> 28) / COS_DENS[k];
      acc = (t > Q28_ONE) ? 64'd0 : Q28_ONE - t;
    end
    return acc;
  endfunction

  function automatic logic [63:0] div_len(input logic [63:0] v, input logic up);
    return up ? v / RAMP_UP_LEN : v / RAMP_DOWN_LEN;
  endfunction

  // 0.5*(1-cos(pi*i/len)) as Q0.16, saturated
  function automatic logic [15:0] rise_q16(input logic [63:0] i, input logic up);
    logic [63:0] len;
    logic [63:0] r;
    len = up ? 64'(RAMP_UP_LEN) : 64'(RAMP_DOWN_LEN);
    if (2 * i <= len) begin
      r = (Q28_ONE - cos_q28(div_len(PI_Q28 * i, up))) >> 1;
    end else begin
      r = (Q28_ONE + cos_q28(div_len(PI_Q28 * (len - i), up))) >> 1;
    end
    r = (r + 64'd2048) >> 12;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [(RAMP_UP_LEN+1)*16-1:0] build_up_rom();
    logic [(RAMP_UP_LEN+1)*16-1:0] rom;
    rom = '0;
    for (int i = 0; i <= int'(RAMP_UP_LEN); i++) begin
      rom[i*16 +: 16] = rise_q16(64'(i), 1'b1);
    end
    return rom;
  endfunction

  function automatic logic [(RAMP_DOWN_LEN+1)*16-1:0] build_dn_rom();
    logic [(RAMP_DOWN_LEN+1)*16-1:0] rom;
    rom = '0;
    for (int i = 0; i <= int'(RAMP_DOWN_LEN); i++) begin
      rom[i*16 +: 16] = rise_q16(64'(int'(RAMP_DOWN_LEN) - i), 1'b0);
    end
    return rom;
  endfunction

  localparam logic [(RAMP_UP_LEN+1)*16-1:0]   RAMP_UP_ROM = build_up_rom();
  localparam logic [(RAMP_DOWN_LEN+1)*16-1:0] RAMP_DN_ROM = build_dn_rom();

endpackage

### hdl/fns_isqrt.sv
// Bit-serial integer square root of the noise power scaled by 2^18.
// Uses fns_pkg for widths and the ser_ctl_t sequencing struct.
module fns_isqrt (
  input  logic                        clk_i,
  input  fns_pkg::ser_ctl_t           ctl_i,
  input  logic [fns_pkg::PW_W-1:0]    pw_i,
  output logic [fns_pkg::MAG_W-1:0]   mag_o
);

  logic [fns_pkg::RAD_W-1:0] rad_q;
  logic [fns_pkg::REM_W-1:0] rem_q;
  logic [fns_pkg::MAG_W-1:0] root_q;

  logic [fns_pkg::REM_W+1:0] rem_sh;
  logic [fns_pkg::REM_W+1:0] trial;
  logic                      fits;

  // bring down the next radicand pair and try root*4+1
  assign rem_sh = {rem_q, rad_q[fns_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rad_q  <= {pw_i, (fns_pkg::RAD_W - fns_pkg::PW_W)'(0)};
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctl_i.step) begin
      rad_q  <= {rad_q[fns_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= fits ? fns_pkg::REM_W'(rem_sh - trial) : fns_pkg::REM_W'(rem_sh);
      root_q <= {root_q[fns_pkg::MAG_W-2:0], fits};
    end
  end

  assign mag_o = root_q;

endmodule

### hdl/fns_avg.sv
// Bit-serial exponential average update: (a*avg + (65536-a)*mag) / 2^16, saturated.
// Uses fns_pkg for widths and the ser_ctl_t sequencing struct.
module fns_avg (
  input  logic                          clk_i,
  input  fns_pkg::ser_ctl_t             ctl_i,
  input  logic [fns_pkg::COEF_W-1:0]    coef_i,
  input  logic [fns_pkg::LEVEL_W-1:0]   avg_i,
  input  logic [fns_pkg::MAG_W-1:0]     mag_i,
  output logic [fns_pkg::LEVEL_W-1:0]   avg_o
);

  localparam int unsigned DigW = fns_pkg::COEF_W + 1;

  logic [fns_pkg::ACC_W-1:0] acc_q;
  logic [DigW-1:0]           a_sh_q;
  logic [DigW-1:0]           b_sh_q;
  logic [fns_pkg::ACC_W-1:0] add_a;
  logic [fns_pkg::ACC_W-1:0] add_b;

  // MSB first: double the sum and add the partial products of this bit
  assign add_a = a_sh_q[DigW-1] ? fns_pkg::ACC_W'(avg_i) : '0;
  assign add_b = b_sh_q[DigW-1] ? fns_pkg::ACC_W'(mag_i) : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      acc_q  <= '0;
      a_sh_q <= {1'b0, coef_i};
      b_sh_q <= {1'b1, fns_pkg::COEF_W'(0)} - {1'b0, coef_i};
    end else if (ctl_i.step) begin
      acc_q  <= {acc_q[fns_pkg::ACC_W-2:0], 1'b0} + add_a + add_b;
      a_sh_q <= {a_sh_q[DigW-2:0], 1'b0};
      b_sh_q <= {b_sh_q[DigW-2:0], 1'b0};
    end
  end

  assign avg_o = acc_q[fns_pkg::ACC_W-1] ? '1 : acc_q[fns_pkg::ACC_W-2 -: fns_pkg::LEVEL_W];

endmodule

### hdl/fm_noise_squelch_core.sv
// FM noise squelch with noise-dependent tail: top level.
// Depends on fns_pkg, fns_isqrt (noise magnitude) and fns_avg (noise averages).
//
// Usage
//   Input words carry one audio I/Q sample and its filtered noise I/Q sample on
//   in_valid_i / in_stall_o; result words carry the gated audio and the squelch
//   mode on out_valid_o / out_stall_i. A word moves at a rising edge where valid
//   is high and stall is low. One result word leaves for every input word.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write
//   it only while no word is in flight.
// Timing
//   With the squelch running, a word passes from acceptance through the noise
//   squares, the bit-serial root (25 steps, one root bit each), the bit-serial
//   average update (17 steps, one coefficient bit each), the tail product and
//   the gating into its result register; only then is a new word taken.
//   With run_enable low the samples pass straight to the result register.
// Reset and stalls
//   Reset restores the register defaults, muted mode, the start-up averages and
//   an empty result register. While the receiver stalls, the result register
//   holds; the next word is still accepted and worked on, then waits at its end.
module fm_noise_squelch_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [fns_pkg::SAMPLE_W-1:0] sig_i_i,
  input  logic signed [fns_pkg::SAMPLE_W-1:0] sig_q_i,
  input  logic signed [fns_pkg::SAMPLE_W-1:0] noise_i_i,
  input  logic signed [fns_pkg::SAMPLE_W-1:0] noise_q_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fns_pkg::SAMPLE_W-1:0] out_i_o,
  output logic signed [fns_pkg::SAMPLE_W-1:0] out_q_o,
  output logic [fns_pkg::MODE_W-1:0]         squelch_mode_o,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [fns_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fns_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = fns_pkg::CNT_W;
  localparam int unsigned SW = fns_pkg::SAMPLE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                         run_en_q;
  logic [fns_pkg::COEF_W-1:0]   short_coef_q;
  logic [fns_pkg::COEF_W-1:0]   long_coef_q;
  logic [fns_pkg::LEVEL_W-1:0]  unmute_lvl_q;
  logic [fns_pkg::LEVEL_W-1:0]  tail_lvl_q;
  logic [CW-1:0]                startup_q;
  logic [CW-1:0]                tail_lo_q;
  logic [CW-1:0]                tail_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_en_q     <= 1'b0;
      short_coef_q <= fns_pkg::SHORT_COEF_RESET;
      long_coef_q  <= fns_pkg::LONG_COEF_RESET;
      unmute_lvl_q <= fns_pkg::UNMUTE_RESET;
      tail_lvl_q   <= fns_pkg::TAIL_LVL_RESET;
      startup_q    <= fns_pkg::STARTUP_RESET;
      tail_lo_q    <= fns_pkg::MIN_TAIL_RESET;
      tail_hi_q    <= fns_pkg::MAX_TAIL_RESET;
    end else if (cfg_we_i) begin
      case (fns_pkg::cfg_idx_e'(cfg_idx_i))
        fns_pkg::CFG_RUN_ENABLE: run_en_q     <= cfg_data_i[0];
        fns_pkg::CFG_SHORT_COEF: short_coef_q <= cfg_data_i[fns_pkg::COEF_W-1:0];
        fns_pkg::CFG_LONG_COEF:  long_coef_q  <= cfg_data_i[fns_pkg::COEF_W-1:0];
        fns_pkg::CFG_UNMUTE_LVL: unmute_lvl_q <= cfg_data_i[fns_pkg::LEVEL_W-1:0];
        fns_pkg::CFG_TAIL_LVL:   tail_lvl_q   <= cfg_data_i[fns_pkg::LEVEL_W-1:0];
        fns_pkg::CFG_STARTUP:    startup_q    <= cfg_data_i[CW-1:0];
        fns_pkg::CFG_MIN_TAIL:   tail_lo_q    <= cfg_data_i[CW-1:0];
        fns_pkg::CFG_MAX_TAIL:   tail_hi_q    <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  fns_pkg::fns_state_e state_q, state_d;
  logic [fns_pkg::SER_CNT_W-1:0] cnt_q;
  logic                          out_valid_q;
  logic                          out_load;
  logic                          in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fns_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_take  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      fns_pkg::S_IDLE: begin
        in_take = in_valid_i;
        if (in_valid_i) begin
          // run off: nothing to compute, go straight to the result
          state_d = run_en_q ? fns_pkg::S_SQ_I : fns_pkg::S_FINISH;
        end
      end
      fns_pkg::S_SQ_I:   state_d = fns_pkg::S_SQ_Q;
      fns_pkg::S_SQ_Q:   state_d = fns_pkg::S_SQRT;
      fns_pkg::S_SQRT:   if (cnt_q == '0) state_d = fns_pkg::S_AVG;
      fns_pkg::S_AVG:    if (cnt_q == '0) state_d = fns_pkg::S_UPD;
      fns_pkg::S_UPD:    state_d = fns_pkg::S_MUL_T;
      fns_pkg::S_MUL_T:  state_d = fns_pkg::S_GATE_I;
      fns_pkg::S_GATE_I: state_d = fns_pkg::S_GATE_Q;
      fns_pkg::S_GATE_Q: state_d = fns_pkg::S_FINISH;
      fns_pkg::S_FINISH: begin
        // hold here until the result register is free
        out_load = !out_valid_q || !out_stall_i;
        if (out_load) state_d = fns_pkg::S_IDLE;
      end
      default: state_d = fns_pkg::S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != fns_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (state_q)
        fns_pkg::S_SQ_Q: cnt_q <= fns_pkg::SER_CNT_W'(fns_pkg::SQRT_STEPS - 1);
        fns_pkg::S_SQRT: begin
          cnt_q <= (cnt_q == '0) ? fns_pkg::SER_CNT_W'(fns_pkg::AVG_STEPS - 1) : cnt_q - 1'b1;
        end
        fns_pkg::S_AVG:  cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input hold and shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] sig_i_q, sig_q_q, noise_i_q, noise_q_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sig_i_q   <= sig_i_i;
      sig_q_q   <= sig_q_i;
      noise_i_q <= noise_i_i;
      noise_q_q <= noise_q_i;
    end
  end

  logic [fns_pkg::LEVEL_W-1:0] short_avg_q, long_avg_q;
  logic [CW-1:0]               step_q;
  fns_pkg::mode_e              mode_q;

  // long average clipped to 1.0 for the tail length
  logic [fns_pkg::MAG_W-1:0] long_clip;
  logic signed [CW:0]        tail_diff;
  assign long_clip = (long_avg_q > fns_pkg::Q24_ONE) ? fns_pkg::MAG_W'(fns_pkg::Q24_ONE)
                                                     : long_avg_q[fns_pkg::MAG_W-1:0];
  assign tail_diff = $signed({1'b0, tail_hi_q}) - $signed({1'b0, tail_lo_q});

  // ramp gain: ROM index is LEN - step, entry 0 once step runs past LEN
  logic [fns_pkg::UP_IDX_W-1:0] up_idx;
  logic [fns_pkg::DN_IDX_W-1:0] dn_idx;
  logic [15:0]                  gain;
  assign up_idx = (step_q > CW'(fns_pkg::RAMP_UP_LEN)) ? '0
                : fns_pkg::UP_IDX_W'(CW'(fns_pkg::RAMP_UP_LEN) - step_q);
  assign dn_idx = (step_q > CW'(fns_pkg::RAMP_DOWN_LEN)) ? '0
                : fns_pkg::DN_IDX_W'(CW'(fns_pkg::RAMP_DOWN_LEN) - step_q);
  assign gain = (mode_q == fns_pkg::MODE_RAMP_UP) ? fns_pkg::RAMP_UP_ROM[up_idx*16 +: 16]
                                                  : fns_pkg::RAMP_DN_ROM[dn_idx*16 +: 16];

  localparam int unsigned MulAW = CW + 1;
  localparam int unsigned MulBW = fns_pkg::MAG_W + 1;
  localparam int unsigned MulPW = MulAW + MulBW;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic signed [MulPW-1:0] gate_sum;

  always_comb begin
    mul_a = tail_diff;
    mul_b = $signed({1'b0, long_clip});
    case (state_q)
      fns_pkg::S_SQ_I: begin
        mul_a = MulAW'(noise_i_q);
        mul_b = MulBW'(noise_i_q);
      end
      fns_pkg::S_SQ_Q: begin
        mul_a = MulAW'(noise_q_q);
        mul_b = MulBW'(noise_q_q);
      end
      fns_pkg::S_GATE_I: begin
        mul_a = MulAW'(sig_i_q);
        mul_b = $signed({(MulBW - 16)'(0), gain});
      end
      fns_pkg::S_GATE_Q: begin
        mul_a = MulAW'(sig_q_q);
        mul_b = $signed({(MulBW - 16)'(0), gain});
      end
      default: ;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  // round half up, keep the Q1.15 bits
  assign gate_sum = mul_p + MulPW'(32768);

  logic [fns_pkg::PW_W-1:0]  pw_q;
  logic [fns_pkg::PW_W-1:0]  pw_sum;
  logic signed [MulPW-1:0]   tail_prod_q;
  logic signed [SW-1:0]      gate_i_q, gate_q_q;

  assign pw_sum = pw_q + mul_p[fns_pkg::PW_W-1:0];

  always_ff @(posedge clk_i) begin
    case (state_q)
      fns_pkg::S_SQ_I:   pw_q        <= mul_p[fns_pkg::PW_W-1:0];
      fns_pkg::S_MUL_T:  tail_prod_q <= mul_p;
      fns_pkg::S_GATE_I: gate_i_q    <= gate_sum[31:16];
      fns_pkg::S_GATE_Q: gate_q_q    <= gate_sum[31:16];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Noise magnitude and averages
  // ---------------------------------------------------------------------------
  fns_pkg::ser_ctl_t           sqrt_ctl, avg_ctl;
  logic [fns_pkg::MAG_W-1:0]   mag;
  logic [fns_pkg::LEVEL_W-1:0] short_new, long_new;

  assign sqrt_ctl.load = (state_q == fns_pkg::S_SQ_Q);
  assign sqrt_ctl.step = (state_q == fns_pkg::S_SQRT);
  assign avg_ctl.load  = (state_q == fns_pkg::S_SQ_Q);
  assign avg_ctl.step  = (state_q == fns_pkg::S_AVG);

  fns_isqrt u_isqrt (
    .clk_i (clk_i),
    .ctl_i (sqrt_ctl),
    .pw_i  (pw_sum),
    .mag_o (mag)
  );

  fns_avg u_short_avg (
    .clk_i  (clk_i),
    .ctl_i  (avg_ctl),
    .coef_i (short_coef_q),
    .avg_i  (short_avg_q),
    .mag_i  (mag),
    .avg_o  (short_new)
  );

  fns_avg u_long_avg (
    .clk_i  (clk_i),
    .ctl_i  (avg_ctl),
    .coef_i (long_coef_q),
    .avg_i  (long_avg_q),
    .mag_i  (mag),
    .avg_o  (long_new)
  );

  // ---------------------------------------------------------------------------
  // Squelch state: averages, start-up delay, mode and step count
  // ---------------------------------------------------------------------------
  logic [CW-1:0] delay_q, delay_inc;
  logic          ready_q;

  assign delay_inc = (!ready_q && delay_q != fns_pkg::CNT_MAX) ? delay_q + 1'b1 : delay_q;

  // tail length = min + (max-min)*clip(long) in Q24, always non-negative
  logic signed [CW+28-1:0] tail_num;
  logic [CW-1:0]           tail_len;
  assign tail_num = $signed({4'b0000, tail_lo_q, 24'd0}) + (CW + 28)'(tail_prod_q);
  assign tail_len = tail_num[CW+23:24];

  fns_pkg::mode_e       mode_d;
  logic [CW-1:0]        step_d;
  logic signed [SW-1:0] res_i, res_q;

  always_comb begin
    mode_d = mode_q;
    step_d = step_q;
    res_i  = sig_i_q;
    res_q  = sig_q_q;
    if (run_en_q) begin
      case (mode_q)
        fns_pkg::MODE_RAMP_UP: begin
          res_i = gate_i_q;
          res_q = gate_q_q;
          if (step_q == '0) mode_d = fns_pkg::MODE_OPEN;
          else              step_d = step_q - 1'b1;
        end
        fns_pkg::MODE_OPEN: begin
          if (short_avg_q > tail_lvl_q) begin
            mode_d = fns_pkg::MODE_TAIL;
            step_d = tail_len;
          end
        end
        fns_pkg::MODE_TAIL: begin
          // noise back down: reopen without a ramp
          if (short_avg_q < unmute_lvl_q) begin
            mode_d = fns_pkg::MODE_OPEN;
          end else if (step_q == '0) begin
            mode_d = fns_pkg::MODE_RAMP_DOWN;
            step_d = CW'(fns_pkg::RAMP_DOWN_LEN);
          end else begin
            step_d = step_q - 1'b1;
          end
        end
        fns_pkg::MODE_RAMP_DOWN: begin
          res_i = gate_i_q;
          res_q = gate_q_q;
          if (step_q == '0) mode_d = fns_pkg::MODE_MUTED;
          else              step_d = step_q - 1'b1;
        end
        default: begin
          res_i = '0;
          res_q = '0;
          if (short_avg_q < unmute_lvl_q && ready_q) begin
            mode_d = fns_pkg::MODE_RAMP_UP;
            step_d = CW'(fns_pkg::RAMP_UP_LEN);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_avg_q <= fns_pkg::SHORT_AVG_RESET;
      long_avg_q  <= fns_pkg::LONG_AVG_RESET;
      delay_q     <= '0;
      ready_q     <= 1'b0;
      mode_q      <= fns_pkg::MODE_MUTED;
      step_q      <= '0;
    end else begin
      if (state_q == fns_pkg::S_UPD) begin
        short_avg_q <= short_new;
        long_avg_q  <= long_new;
        delay_q     <= delay_inc;
        ready_q     <= ready_q || (delay_inc >= startup_q);
      end
      // run off leaves mode and count frozen
      if (out_load && run_en_q) begin
        mode_q <= mode_d;
        step_q <= step_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] out_i_q, out_q_q;
  fns_pkg::mode_e       out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_i_q    <= res_i;
      out_q_q    <= res_q;
      out_mode_q <= mode_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_i_o        = out_i_q;
  assign out_q_o        = out_q_q;
  assign squelch_mode_o = out_mode_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ramp_up_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == fns_pkg::MODE_RAMP_UP) |-> (step_q <= CW'(fns_pkg::RAMP_UP_LEN)))
    else $error("ramp-up count beyond ramp length");

  a_ramp_dn_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == fns_pkg::MODE_RAMP_DOWN) |-> (step_q <= CW'(fns_pkg::RAMP_DOWN_LEN)))
    else $error("ramp-down count beyond ramp length");

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ready_q))
    else $error("start-up ready flag dropped");

  a_mode_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fns_pkg::S_FINISH) |=> $stable(mode_q))
    else $error("mode changed outside the finish step");

  a_avg_at_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fns_pkg::S_UPD) |=> ($stable(short_avg_q) && $stable(long_avg_q)))
    else $error("noise averages changed outside the update step");

endmodule
